>>> src/drtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drtm_pkg
// Shared constants, codes and inter-stage types of the descriptor ratio-test
// matcher.
// ----------------------------------------------------------------------------
package drtm_pkg;

    localparam int DESC_LEN       = 128;
    localparam int MAX_CANDIDATES = 4096;
    localparam int ADDR_W         = $clog2(DESC_LEN);

    localparam int ELEM_W  = 7;
    localparam int VALUE_W = 8;
    localparam int ROW_W   = 16;
    localparam int CAND_W  = 12;
    localparam int SQ_W    = 2 * VALUE_W;
    localparam int ACC_W   = 24;
    localparam int DIST_W  = 20;
    localparam int RATIO_W = 9;
    localparam int CFG_W   = 16;

    localparam logic [DIST_W-1:0] DIST_INIT = DIST_W'(1000000);
    localparam logic [ACC_W-1:0]  ACC_MAX   = {ACC_W{1'b1}};

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_CAND = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        REG_EPIPOLAR = 1'b0,
        REG_RATIO    = 1'b1
    } cfg_reg_t;

    // Item after the squaring stage
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic              in_range;
        logic              cand_ok;
        logic [SQ_W-1:0]   sq;
        logic [ROW_W-1:0]  point_y;
        logic [CAND_W-1:0] cand_index;
        logic              last_el;
        logic              last_cand;
    } sq_item_t;

    // Snapshot of the search registers at the end of a search
    typedef struct packed {
        logic              valid;
        logic              have;
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] second;
        logic [CAND_W-1:0] index;
    } fin_t;

endpackage

>>> src/drtm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drtm_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module drtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/drtm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drtm_front
// Input register, query descriptor store and element difference squaring.
// ----------------------------------------------------------------------------
module drtm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic                               op,
    input  logic [drtm_pkg::ELEM_W-1:0]        element_index,
    input  logic [drtm_pkg::VALUE_W-1:0]       value,
    input  logic [drtm_pkg::ROW_W-1:0]         point_y,
    input  logic [drtm_pkg::CAND_W-1:0]        candidate_index,
    input  logic                               last_element,
    input  logic                               last_candidate,
    output drtm_pkg::sq_item_t                 s2
);
    import drtm_pkg::*;

    logic                accept;
    logic                in_range;
    logic [ADDR_W-1:0]   addr;
    logic [VALUE_W-1:0]  q_value;

    logic                s1_valid_reg;
    op_t                 s1_op_reg;
    logic                s1_range_reg;
    logic                s1_cand_ok_reg;
    logic [VALUE_W-1:0]  s1_value_reg;
    logic [ROW_W-1:0]    s1_point_y_reg;
    logic [CAND_W-1:0]   s1_cand_reg;
    logic                s1_last_el_reg;
    logic                s1_last_cand_reg;

    logic [VALUE_W-1:0]  diff;
    sq_item_t            s2_next;
    sq_item_t            s2_reg;

    assign accept   = in_valid && adv;
    assign in_range = 32'(element_index) < DESC_LEN;
    assign addr     = ADDR_W'(element_index);

    // Loads write at acceptance, candidates read at acceptance: order is kept
    drtm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DESC_LEN)
    ) u_query_ram (
        .clk   (clk),
        .we    (accept && (op_t'(op) == OP_LOAD) && in_range),
        .waddr (addr),
        .wdata (value),
        .re    (accept && (op_t'(op) == OP_CAND)),
        .raddr (addr),
        .rdata (q_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg        <= op_t'(op);
            s1_range_reg     <= in_range;
            s1_cand_ok_reg   <= 32'(candidate_index) < MAX_CANDIDATES;
            s1_value_reg     <= value;
            s1_point_y_reg   <= point_y;
            s1_cand_reg      <= candidate_index;
            s1_last_el_reg   <= last_element;
            s1_last_cand_reg <= last_candidate;
        end
    end

    assign diff = (q_value > s1_value_reg) ? (q_value - s1_value_reg)
                                           : (s1_value_reg - q_value);

    always_comb
    begin
        s2_next.valid      = s1_valid_reg;
        s2_next.op         = s1_op_reg;
        s2_next.in_range   = s1_range_reg;
        s2_next.cand_ok    = s1_cand_ok_reg;
        s2_next.sq         = SQ_W'(diff) * SQ_W'(diff);
        s2_next.point_y    = s1_point_y_reg;
        s2_next.cand_index = s1_cand_reg;
        s2_next.last_el    = s1_last_el_reg;
        s2_next.last_cand  = s1_last_cand_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else if (adv)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

>>> src/drtm_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drtm_search
// Distance accumulation, epipolar gate and best / second-best tracking.
// ----------------------------------------------------------------------------
module drtm_search (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  drtm_pkg::sq_item_t           s2,
    input  logic [drtm_pkg::ROW_W-1:0]   epipolar_thr,
    output drtm_pkg::fin_t               fin
);
    import drtm_pkg::*;

    logic [ROW_W-1:0]   row_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [DIST_W-1:0]  best_reg;
    logic [DIST_W-1:0]  second_reg;
    logic [CAND_W-1:0]  index_reg;
    logic               have_reg;
    fin_t               fin_reg;

    logic [ACC_W:0]     sum_wide;
    logic [ACC_W-1:0]   acc_sum;
    logic [ROW_W-1:0]   gap;
    logic               keep;
    logic               take_best;
    logic               take_second;
    logic [DIST_W-1:0]  best_next;
    logic [DIST_W-1:0]  second_next;
    logic [CAND_W-1:0]  index_next;
    logic               have_next;
    logic               do_step;

    assign do_step  = adv && s2.valid;
    assign sum_wide = {1'b0, acc_reg} + (ACC_W + 1)'(s2.sq);

    always_comb
    begin
        if (!s2.in_range)
        begin
            acc_sum = acc_reg;
        end
        else if (sum_wide[ACC_W])
        begin
            acc_sum = ACC_MAX;
        end
        else
        begin
            acc_sum = sum_wide[ACC_W-1:0];
        end
    end

    assign gap = (s2.point_y > row_reg) ? (s2.point_y - row_reg) : (row_reg - s2.point_y);
    assign keep = (gap < epipolar_thr) && s2.cand_ok;

    // ties with best fall through to the second-best test
    assign take_best   = keep && (acc_sum < ACC_W'(best_reg));
    assign take_second = keep && !take_best && (acc_sum < ACC_W'(second_reg));

    always_comb
    begin
        best_next   = best_reg;
        second_next = second_reg;
        index_next  = index_reg;
        have_next   = have_reg;
        if (take_best)
        begin
            second_next = best_reg;
            best_next   = acc_sum[DIST_W-1:0];
            index_next  = s2.cand_index;
            have_next   = 1'b1;
        end
        else if (take_second)
        begin
            second_next = acc_sum[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            acc_reg    <= '0;
            best_reg   <= DIST_INIT;
            second_reg <= DIST_INIT;
            index_reg  <= '0;
            have_reg   <= 1'b0;
        end
        else if (do_step)
        begin
            if (s2.op == OP_LOAD)
            begin
                row_reg <= s2.point_y;
            end
            else if (!s2.last_el)
            begin
                acc_reg <= acc_sum;
            end
            else
            begin
                acc_reg <= '0;
                if (s2.last_cand)
                begin
                    best_reg   <= DIST_INIT;
                    second_reg <= DIST_INIT;
                    index_reg  <= '0;
                    have_reg   <= 1'b0;
                end
                else
                begin
                    best_reg   <= best_next;
                    second_reg <= second_next;
                    index_reg  <= index_next;
                    have_reg   <= have_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg <= '0;
        end
        else if (adv)
        begin
            fin_reg.valid  <= s2.valid && (s2.op == OP_CAND) && s2.last_el && s2.last_cand;
            fin_reg.have   <= have_next;
            fin_reg.best   <= best_next;
            fin_reg.second <= second_next;
            fin_reg.index  <= index_next;
        end
    end

    assign fin = fin_reg;

endmodule

>>> src/drtm_ratio.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drtm_ratio
// Ratio test on the final best / second-best pair and the result register.
// ----------------------------------------------------------------------------
module drtm_ratio (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  drtm_pkg::fin_t                fin,
    input  logic [drtm_pkg::RATIO_W-1:0]  ratio_thr,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          match_found,
    output logic [drtm_pkg::CAND_W-1:0]   match_index,
    output logic [drtm_pkg::DIST_W-1:0]   best_distance
);
    import drtm_pkg::*;

    localparam int PROD_W = RATIO_W + DIST_W;

    logic [PROD_W-1:0]  lhs;
    logic [PROD_W-1:0]  rhs;
    logic               found;
    logic               load;

    logic               out_valid_reg;
    logic               found_reg;
    logic [CAND_W-1:0]  index_reg;
    logic [DIST_W-1:0]  best_reg;

    // best * 256 < ratio * second
    assign lhs   = PROD_W'({fin.best, 8'h00});
    assign rhs   = PROD_W'(ratio_thr) * PROD_W'(fin.second);
    assign found = fin.have && (lhs < rhs);
    assign load  = adv && fin.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_reg <= found;
            index_reg <= found ? fin.index : '0;
            best_reg  <= fin.best;
        end
    end

    assign out_valid     = out_valid_reg;
    assign match_found   = found_reg;
    assign match_index   = index_reg;
    assign best_distance = best_reg;

endmodule

>>> src/descriptor_ratio_test_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_ratio_test_matcher_top
// Nearest-neighbour matcher with ratio test for one query descriptor.
// ----------------------------------------------------------------------------
// Throughput: one input transaction per cycle while the pipeline is not halted.
// Result path: the final element of the final candidate passes the input
//   register + query RAM read, squaring, accumulate/compare, and the ratio
//   test into the result register, where the result is then valid.
// The pipeline halts only when a second result reaches the ratio stage while
//   the previous one is still waiting in the result register.
// Reset: asynchronous, active low; registers return to their defaults
//   (epipolar 164, ratio 205), search state cleared, query RAM not cleared.
// ----------------------------------------------------------------------------
module descriptor_ratio_test_matcher_top (
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_index,
    input  logic [drtm_pkg::CFG_W-1:0]    cfg_data,

    // input transactions
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [drtm_pkg::ELEM_W-1:0]   element_index,
    input  logic [drtm_pkg::VALUE_W-1:0]  value,
    input  logic [drtm_pkg::ROW_W-1:0]    point_y,
    input  logic [drtm_pkg::CAND_W-1:0]   candidate_index,
    input  logic                          last_element,
    input  logic                          last_candidate,

    // result transactions
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          match_found,
    output logic [drtm_pkg::CAND_W-1:0]   match_index,
    output logic [drtm_pkg::DIST_W-1:0]   best_distance
);
    import drtm_pkg::*;

    logic [ROW_W-1:0]    epipolar_reg;
    logic [RATIO_W-1:0]  ratio_reg;
    logic                adv;
    sq_item_t            s2;
    fin_t                fin;

    // Configuration: always ready; user writes only while idle, not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epipolar_reg <= ROW_W'(164);
            ratio_reg    <= RATIO_W'(205);
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_EPIPOLAR: epipolar_reg <= cfg_data[ROW_W-1:0];
                REG_RATIO:    ratio_reg    <= cfg_data[RATIO_W-1:0];
                default:      ;
            endcase
        end
    end

    // Whole pipeline advances together. It halts only when a finished search
    // waits to enter a result register that still holds an untaken result;
    // results are rare, but candidate streaming is held up too while it lasts.
    assign adv      = !(fin.valid && out_valid && !out_ready);
    assign in_ready = adv;

    // Stage 1/2: input register, query RAM lookup, |q - v|^2
    drtm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_valid        (in_valid),
        .op              (op),
        .element_index   (element_index),
        .value           (value),
        .point_y         (point_y),
        .candidate_index (candidate_index),
        .last_element    (last_element),
        .last_candidate  (last_candidate),
        .s2              (s2)
    );

    // Stage 3: accumulate, epipolar gate, best / second-best update.
    // Query row is updated here so that it stays in order with candidates.
    drtm_search u_search (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .s2           (s2),
        .epipolar_thr (epipolar_reg),
        .fin          (fin)
    );

    // Stage 4: ratio test and result register
    drtm_ratio u_ratio (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .fin           (fin),
        .ratio_thr     (ratio_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .match_found   (match_found),
        .match_index   (match_index),
        .best_distance (best_distance)
    );

endmodule
